FILE: rtl/irc_lt_pkg.sv
// Shared types and constants for the IRC line tokenizer.
// Holds the result word layout, phase/kind/status codes and the command keyword table.
// No dependencies.
`default_nettype none

package irc_lt_pkg;

    // One classified result word
    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] field_kind;
        logic [3:0] param_index;
        logic       token_start;
        logic       line_end;
        logic [3:0] command_type;
        logic [1:0] line_status;
        logic       has_trailing;
        logic [3:0] param_total;
    } res_t;

    // Parser phases
    localparam logic [2:0] PH_START  = 3'd0;
    localparam logic [2:0] PH_PREFIX = 3'd1;
    localparam logic [2:0] PH_GAP    = 3'd2;
    localparam logic [2:0] PH_CMD    = 3'd3;
    localparam logic [2:0] PH_PARAMS = 3'd4;
    localparam logic [2:0] PH_TRAIL  = 3'd5;

    // Field kinds
    localparam logic [2:0] KIND_SKIP     = 3'd0;
    localparam logic [2:0] KIND_PREFIX   = 3'd1;
    localparam logic [2:0] KIND_COMMAND  = 3'd2;
    localparam logic [2:0] KIND_PARAM    = 3'd3;
    localparam logic [2:0] KIND_TRAILING = 3'd4;
    localparam logic [2:0] KIND_LINE_END = 3'd5;

    // Line status codes
    localparam logic [1:0] ST_DISPATCH   = 2'd0;
    localparam logic [1:0] ST_NEED_MORE  = 2'd1;
    localparam logic [1:0] ST_EMPTY_LINE = 2'd2;

    // Command types
    localparam logic [3:0] TYPE_OTHER = 4'd0;
    localparam logic [3:0] TYPE_PING  = 4'd2;
    localparam logic [3:0] TYPE_QUIT  = 4'd8;

    // Byte codes
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_COLON = 8'h3A;

    // Keyword table, first character in the low byte; index t gives type t+1
    localparam int NUM_KW = 8;
    localparam logic [63:0] KW_BYTES [NUM_KW] = '{
        64'h0000_0000_0050_4143,   // CAP
        64'h0000_0000_474E_4950,   // PING
        64'h0000_0000_5353_4150,   // PASS
        64'h0000_0000_4B43_494E,   // NICK
        64'h0000_0000_5245_5355,   // USER
        64'h0000_0000_4E49_4F4A,   // JOIN
        64'h0047_534D_5649_5250,   // PRIVMSG
        64'h0000_0000_5449_5551    // QUIT
    };
    localparam logic [3:0] KW_LEN [NUM_KW] = '{
        4'd3, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd7, 4'd4
    };

    // Output queue geometry
    localparam int          Q_DEPTH = 4;
    localparam int          Q_PW    = 2;
    localparam logic [2:0]  Q_FULL  = 3'd4;
    localparam logic [2:0]  Q_ROOM2 = 3'd2;

endpackage

`default_nettype wire

FILE: rtl/irc_line_tokenizer_core.sv
// IRC line tokenizer: tags each received byte with its field and reports each CR LF line.
// Uses irc_lt_pkg (types, codes, keyword table) and irc_lt_queue (result queue).
//
// Usage:
//   Input channel s_*: one received byte per word in s_tdata[7:0].
//   Output channel m_*: one result word per classified byte, plus one word per
//   line end (m_tlast high, m_tuser = line end kind, summary fields in tdata).
// Path: an accepted byte is held in the input register, classified from it and
//   written to the result queue when the queue has room; m_* is driven from the
//   queue head.
// Throughput: one byte per cycle while the result queue has room. A CR is held
//   back until the next byte; a held CR followed by a byte other than LF or CR
//   yields two words from that next byte. The input register advances only while
//   the four-word result queue has two free entries, so a stalled receiver backs
//   up into s_tready after at most four words plus the input register.
// Reset: all line state, the held CR and the queue are cleared; the block
//   starts at the beginning of a line.
`default_nettype none

module irc_line_tokenizer_core #(
    parameter int MAX_KEYWORD_BYTES = 7,
    parameter int PARAM_INDEX_MAX   = 15
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [7:0] out_byte, [11:8] param_index,
                                        // [12] token_start, [16:13] command_type,
                                        // [18:17] line_status, [19] has_trailing,
                                        // [23:20] param_total
    output logic [2:0]       m_tuser,   // [2:0] field_kind
    output logic             m_tlast    // line_end
);
    import irc_lt_pkg::*;

    localparam int KW_W  = MAX_KEYWORD_BYTES * 8;
    localparam int LEN_W = $clog2(MAX_KEYWORD_BYTES + 1);
    localparam int PC_W  = $clog2(PARAM_INDEX_MAX + 1);

    typedef struct packed {
        logic [2:0]       phase;
        logic [KW_W-1:0]  kw_bytes;
        logic [LEN_W-1:0] kw_len;
        logic             kw_long;
        logic [PC_W-1:0]  pcount;
        logic             in_tok;
        logic             saw_sp;
        logic             trail;
        logic             has_bytes;
    } line_state_t;

    // Width helper: counter value masked to the 4-bit output fields
    function automatic logic [3:0] to4(input logic [PC_W-1:0] v);
        logic [PC_W+3:0] ext;
        ext = {4'b0000, v};
        return ext[3:0];
    endfunction

    function automatic line_state_t key_append(input line_state_t si, input logic [7:0] b);
        line_state_t so;
        so = si;
        if (si.kw_len < LEN_W'(MAX_KEYWORD_BYTES))
        begin
            so.kw_bytes[8*si.kw_len +: 8] = b;
            so.kw_len = si.kw_len + 1'b1;
        end
        else
        begin
            so.kw_long = 1'b1;
        end
        return so;
    endfunction

    function automatic logic [3:0] key_type(input line_state_t s);
        logic [3:0] ct;
        logic       ok;
        ct = TYPE_OTHER;
        for (int t = 0; t < NUM_KW; t++)
        begin
            ok = (4'(s.kw_len) == KW_LEN[t]) && !s.kw_long && (s.kw_len != '0);
            for (int i = 0; i < MAX_KEYWORD_BYTES; i++)
            begin
                if (4'(i) < KW_LEN[t] && s.kw_bytes[8*i +: 8] != KW_BYTES[t][8*i +: 8])
                begin
                    ok = 1'b0;
                end
            end
            if (ok && ct == TYPE_OTHER)
            begin
                ct = 4'(t + 1);
            end
        end
        return ct;
    endfunction

    // One byte through the field parser
    function automatic void classify(input line_state_t si, input logic [7:0] b,
                                     output line_state_t so, output res_t r);
        so = si;
        r = '0;
        r.out_byte = b;
        so.has_bytes = 1'b1;
        case (si.phase)
            PH_START, PH_GAP:
            begin
                if (b == CH_SP)
                begin
                    r.field_kind = KIND_SKIP;
                end
                else if (si.phase == PH_START && b == CH_COLON)
                begin
                    r.field_kind = KIND_PREFIX;
                    r.token_start = 1'b1;
                    so.phase = PH_PREFIX;
                end
                else
                begin
                    r.field_kind = KIND_COMMAND;
                    r.token_start = 1'b1;
                    so = key_append(so, b);
                    so.phase = PH_CMD;
                end
            end
            PH_PREFIX:
            begin
                if (b == CH_SP)
                begin
                    r.field_kind = KIND_SKIP;
                    so.phase = PH_GAP;
                end
                else
                begin
                    r.field_kind = KIND_PREFIX;
                end
            end
            PH_CMD:
            begin
                if (b == CH_SP)
                begin
                    r.field_kind = KIND_SKIP;
                    so.saw_sp = 1'b1;
                    so.in_tok = 1'b0;
                    so.phase = PH_PARAMS;
                end
                else
                begin
                    r.field_kind = KIND_COMMAND;
                    so = key_append(so, b);
                end
            end
            PH_PARAMS:
            begin
                if (b == CH_COLON)
                begin
                    r.field_kind = KIND_TRAILING;
                    r.token_start = 1'b1;
                    r.param_index = to4(si.pcount);
                    so.trail = 1'b1;
                    so.in_tok = 1'b0;
                    so.phase = PH_TRAIL;
                end
                else if (b inside {CH_SP, [CH_TAB:CH_CR]})
                begin
                    r.field_kind = KIND_SKIP;
                    so.in_tok = 1'b0;
                end
                else
                begin
                    r.field_kind = KIND_PARAM;
                    if (!si.in_tok)
                    begin
                        r.token_start = 1'b1;
                        so.in_tok = 1'b1;
                        if (si.pcount < PC_W'(PARAM_INDEX_MAX))
                        begin
                            so.pcount = si.pcount + 1'b1;
                        end
                    end
                    if (so.pcount != '0)
                    begin
                        r.param_index = to4(so.pcount - 1'b1);
                    end
                end
            end
            default:
            begin
                r.field_kind = KIND_TRAILING;
                r.param_index = to4(si.pcount);
            end
        endcase
    endfunction

    // Line summary word
    function automatic res_t line_done(input line_state_t s);
        res_t r;
        r = '0;
        r.field_kind   = KIND_LINE_END;
        r.line_end     = 1'b1;
        r.command_type = key_type(s);
        r.has_trailing = s.trail;
        r.param_total  = to4(s.pcount);
        if (s.saw_sp)
        begin
            r.line_status = ST_DISPATCH;
        end
        else if (!s.has_bytes)
        begin
            r.line_status = ST_EMPTY_LINE;
        end
        else if (r.command_type == TYPE_PING || r.command_type == TYPE_QUIT)
        begin
            r.line_status = ST_DISPATCH;
        end
        else
        begin
            r.line_status = ST_NEED_MORE;
        end
        return r;
    endfunction

    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    line_state_t  st_reg;
    line_state_t  st_next;
    logic         cr_held_reg;
    logic         cr_held_next;
    logic         advance;
    logic         room2;
    logic [1:0]   push_n;
    logic         done_now;
    res_t         res0;
    res_t         res1;
    res_t         head;
    line_state_t  st_mid;

    // Input register
    assign advance  = in_valid_reg && room2;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
        end
    end

    // Classification of the registered byte, with the held CR in front of it
    always_comb
    begin
        st_next      = st_reg;
        st_mid       = st_reg;
        cr_held_next = cr_held_reg;
        res0         = '0;
        res1         = '0;
        push_n       = 2'd0;
        done_now     = 1'b0;
        if (cr_held_reg)
        begin
            if (in_byte_reg == CH_LF)
            begin
                res0         = line_done(st_reg);
                st_next      = '0;
                st_next.phase = PH_START;
                cr_held_next = 1'b0;
                push_n       = 2'd1;
                done_now     = 1'b1;
            end
            else
            begin
                classify(st_reg, CH_CR, st_mid, res0);
                st_next = st_mid;
                if (in_byte_reg == CH_CR)
                begin
                    cr_held_next = 1'b1;
                    push_n       = 2'd1;
                end
                else
                begin
                    classify(st_mid, in_byte_reg, st_next, res1);
                    cr_held_next = 1'b0;
                    push_n       = 2'd2;
                end
            end
        end
        else if (in_byte_reg == CH_CR)
        begin
            cr_held_next = 1'b1;
        end
        else
        begin
            classify(st_reg, in_byte_reg, st_next, res0);
            push_n = 2'd1;
        end
    end

    // Line state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg       <= '0;
            cr_held_reg  <= 1'b0;
        end
        else if (advance)
        begin
            st_reg       <= st_next;
            cr_held_reg  <= cr_held_next;
        end
    end

    // Result queue
    irc_lt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_n    (advance ? push_n : 2'd0),
        .push0     (res0),
        .push1     (res1),
        .room2     (room2),
        .out_valid (m_tvalid),
        .out_word  (head),
        .out_ready (m_tready)
    );

    // Output word packing
    assign m_tdata = {head.param_total, head.has_trailing, head.line_status,
                      head.command_type, head.token_start, head.param_index,
                      head.out_byte};
    assign m_tuser = head.field_kind;
    assign m_tlast = head.line_end;

    // checks
    a_last_is_line_end: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (m_tuser == KIND_LINE_END))
        else $error("tlast on a word that is not a line end");

    a_start_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[12]) |-> (m_tuser != KIND_SKIP && m_tuser != KIND_LINE_END))
        else $error("token start on a skipped or line end word");

    a_line_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && done_now) |=> (st_reg.phase == PH_START && st_reg.pcount == '0
                                   && !cr_held_reg))
        else $error("line state not cleared after line end");

    a_cr_held: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_byte_reg == CH_CR) |=> cr_held_reg)
        else $error("CR not held");

endmodule

`default_nettype wire

FILE: rtl/irc_lt_queue.sv
// Four-entry IRC line tokenizer result queue: up to two words in, one out per ready cycle.
// Uses irc_lt_pkg for the result word type and queue geometry.
`default_nettype none

module irc_lt_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [1:0]        push_n,    // words to write this cycle, 0..2
    input  wire irc_lt_pkg::res_t  push0,
    input  wire irc_lt_pkg::res_t  push1,
    output logic                   room2,     // at least two free entries
    output logic                   out_valid,
    output irc_lt_pkg::res_t       out_word,
    input  wire logic              out_ready
);
    import irc_lt_pkg::*;

    res_t             entry_reg [Q_DEPTH];
    logic [Q_PW-1:0]  wr_ptr_reg;
    logic [Q_PW-1:0]  rd_ptr_reg;
    logic [2:0]       count_reg;
    logic [2:0]       count_next;
    logic             pop;
    logic [Q_PW-1:0]  wr_ptr1;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != 3'd0);
    assign out_word  = entry_reg[rd_ptr_reg];
    assign room2     = (count_reg <= Q_ROOM2);
    assign wr_ptr1   = wr_ptr_reg + 1'b1;

    // occupancy
    always_comb
    begin
        count_next = count_reg + {1'b0, push_n} - {2'b00, pop};
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + push_n;
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push0;
        end
        if (push_n == 2'd2)
        begin
            entry_reg[wr_ptr1] <= push1;
        end
    end

    // checks
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= Q_FULL)
        else $error("result queue overflow");

    a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push_n != 2'd0) |-> (count_reg <= Q_ROOM2))
        else $error("push without room");

endmodule

`default_nettype wire
